>>> rtl/dmxsf_pkg.sv
// Package for the DMX universe store and sACN packet framer.
// Holds the shared field widths, operation and register codes, and the packet constant tables.
// No dependencies; imported by dmxsf_if.sv and dmx_universe_sacn_framer.sv.
`default_nettype none

package dmxsf_pkg;

  // Upper bound and default for the number of channels in the universe.
  localparam int unsigned CHANNEL_COUNT_MAX = 512;
  localparam int unsigned CHANNEL_COUNT_DEF = 512;

  // Field widths of the transaction, configuration and timer fields.
  localparam int unsigned ModeW   = 3;
  localparam int unsigned ChanW   = 10;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned OffW    = 10;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned MsW     = 17;

  typedef logic [ModeW-1:0]   mode_t;
  typedef logic [ChanW-1:0]   chan_t;
  typedef logic [ByteW-1:0]   byte_t;
  typedef logic [OffW-1:0]    off_t;
  typedef logic [CfgIdxW-1:0] cfg_idx_t;
  typedef logic [CfgW-1:0]    cfg_data_t;

  // Operation codes carried in the mode field.
  typedef enum logic [ModeW-1:0] {
    MODE_WRITE  = 3'd0,
    MODE_MERGE  = 3'd1,
    MODE_CLEAR  = 3'd2,
    MODE_TICK   = 3'd3,
    MODE_READ   = 3'd4,
    MODE_PACKET = 3'd5
  } mode_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_UNIVERSE = 2'd0,
    CFG_PRIORITY = 2'd1,
    CFG_EXPIRE   = 2'd2
  } cfg_idx_e;

  localparam logic [15:0] UNIVERSE_RST = 16'd0;
  localparam logic [7:0]  PRIORITY_RST = 8'd100;
  localparam logic [15:0] EXPIRE_RST   = 16'd1000;

  // Packet layout: the header length, and the offsets of fixed fields.
  localparam int unsigned HDR_LEN       = 126;
  localparam int unsigned OFF_PREAMBLE  = 1;
  localparam int unsigned OFF_IDENT     = 4;
  localparam int unsigned IDENT_LEN     = 12;
  localparam int unsigned OFF_ROOT_FL   = 16;
  localparam int unsigned OFF_ROOT_VEC  = 21;
  localparam int unsigned OFF_FRAME_FL  = 38;
  localparam int unsigned OFF_FRAME_VEC = 43;
  localparam int unsigned OFF_NAME      = 44;
  localparam int unsigned NAME_LEN      = 64;
  localparam int unsigned OFF_PRIORITY  = 108;
  localparam int unsigned OFF_SEQUENCE  = 111;
  localparam int unsigned OFF_UNIV_HI   = 113;
  localparam int unsigned OFF_UNIV_LO   = 114;
  localparam int unsigned OFF_DMP_FL    = 115;
  localparam int unsigned OFF_DMP_VEC   = 117;
  localparam int unsigned OFF_ADDR_TYPE = 118;
  localparam int unsigned OFF_ADDR_INC  = 122;
  localparam int unsigned OFF_COUNT_HI  = 123;
  localparam int unsigned OFF_COUNT_LO  = 124;

  localparam byte_t PREAMBLE_SIZE = 8'h10;
  localparam byte_t ROOT_VECTOR   = 8'h04;
  localparam byte_t FRAME_VECTOR  = 8'h02;
  localparam byte_t DMP_VECTOR    = 8'h02;
  localparam byte_t ADDR_TYPE     = 8'hA1;
  localparam byte_t ADDR_INC      = 8'h01;
  localparam byte_t FLAGS_BASE    = 8'h70;
  localparam int unsigned LEN_NIB_MASK = 'h0F;

  // Packet identifier, "ASC-E1.17" padded with zeros.
  localparam byte_t ACN_IDENT [IDENT_LEN] = '{
    8'h41, 8'h53, 8'h43, 8'h2D, 8'h45, 8'h31,
    8'h2E, 8'h31, 8'h37, 8'h00, 8'h00, 8'h00
  };

  // Source name field, fixed at build time.
  localparam byte_t SOURCE_NAME [NAME_LEN] = '{default: 8'h00};

  // Flags-and-length word of a layer that runs for len bytes.
  function automatic byte_t flags_hi(input int unsigned len);
    return byte_t'(FLAGS_BASE | ((len >> 8) & LEN_NIB_MASK));
  endfunction

  function automatic byte_t flags_lo(input int unsigned len);
    return byte_t'(len & 'hFF);
  endfunction

endpackage

`default_nettype wire

>>> rtl/dmxsf_if.sv
// Valid/ready channel interfaces for the sACN framer: the operation input and the result output.
// Depends on dmxsf_pkg for the payload types.
`default_nettype none

interface dmxsf_in_if;
  import dmxsf_pkg::*;

  logic  valid;
  logic  ready;
  mode_t mode;
  chan_t channel;
  byte_t value;
  byte_t other_value;
  off_t  packet_offset;

  modport source (output valid, output mode, output channel, output value,
                  output other_value, output packet_offset, input ready);
  modport sink   (input valid, input mode, input channel, input value,
                  input other_value, input packet_offset, output ready);
endinterface

interface dmxsf_out_if;
  import dmxsf_pkg::*;

  logic  valid;
  logic  ready;
  byte_t data_byte;
  logic  last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

>>> rtl/dmx_universe_sacn_framer.sv
// Top level of the DMX universe store and sACN data packet framer.
// Depends on dmxsf_pkg, the channel interfaces in dmxsf_if.sv and the RAM in dmxsf_ram.sv.
`default_nettype none

// The block keeps one DMX universe of CHANNEL_COUNT channel bytes and serves the bytes of an
// E1.31 data packet built around it, one byte per transaction at the offset asked for. It takes
// one transaction every clock cycle while in_i.ready is high. Writes, merges, clears and ticks
// take effect at the edge that accepts them and give no result. A channel read or a packet byte
// request is loaded into the first stage at the accepting edge, together with the registered
// read of the channel RAM, and its result moves into the output register once that register is
// free or being taken. Both stages keep advancing while the output side takes results. When the
// output side stalls, transactions without a result keep flowing, and the input stalls once a
// second result waits in the first stage behind the one held at the output. Channel bytes live
// in two RAMs (even and odd channels) with an entry valid bit each, and one valid flip-flop per
// pair of channels, so a clear-all drops every channel by clearing those flip-flops and needs
// no clearing pass after reset. Reads return zero for channels out of range, never written
// since the last clear, or once more than CFG_EXPIRE millisecond ticks have passed since the
// last write or merge. The sequence byte advances after the final packet byte has been
// requested. Configuration writes are to be made only while no transaction is in flight.
module dmx_universe_sacn_framer #(
  parameter int unsigned CHANNEL_COUNT = dmxsf_pkg::CHANNEL_COUNT_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  dmxsf_in_if.sink                  in_i,
  dmxsf_out_if.source               out_o,
  input  wire logic                 cfg_we_i,
  input  wire dmxsf_pkg::cfg_idx_t  cfg_idx_i,
  input  wire dmxsf_pkg::cfg_data_t cfg_data_i
);

  import dmxsf_pkg::*;

  // Channels are stored in pairs: one row holds an even and an odd channel.
  localparam int unsigned ROWS    = (CHANNEL_COUNT + 1) / 2;
  localparam int unsigned RW      = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned PKT_LEN = HDR_LEN + CHANNEL_COUNT;
  localparam int unsigned SLOTS   = CHANNEL_COUNT + 1;

  localparam byte_t ROOT_FH  = flags_hi(PKT_LEN - OFF_ROOT_FL);
  localparam byte_t ROOT_FLO = flags_lo(PKT_LEN - OFF_ROOT_FL);
  localparam byte_t FRM_FH   = flags_hi(PKT_LEN - OFF_FRAME_FL);
  localparam byte_t FRM_FLO  = flags_lo(PKT_LEN - OFF_FRAME_FL);
  localparam byte_t DMP_FH   = flags_hi(PKT_LEN - OFF_DMP_FL);
  localparam byte_t DMP_FLO  = flags_lo(PKT_LEN - OFF_DMP_FL);
  localparam byte_t SLOTS_HI = byte_t'(SLOTS >> 8);
  localparam byte_t SLOTS_LO = byte_t'(SLOTS & 'hFF);

  // Everything the result stage needs from the accepted transaction.
  typedef struct packed {
    logic  last;
    logic  use_chan;
    logic  chan_ok;
    logic  lane;
    byte_t hdr;
  } s1_t;

  // Header byte at an offset below the start of the channel data.
  function automatic byte_t hdr_byte(input off_t off, input byte_t prio, input byte_t seq,
                                     input logic [15:0] univ);
    byte_t b;
    b = 8'h00;
    if (off >= off_t'(OFF_IDENT) && off < off_t'(OFF_IDENT + IDENT_LEN)) begin
      b = ACN_IDENT[4'(off - off_t'(OFF_IDENT))];
    end else if (off >= off_t'(OFF_NAME) && off < off_t'(OFF_NAME + NAME_LEN)) begin
      b = SOURCE_NAME[6'(off - off_t'(OFF_NAME))];
    end else begin
      case (off)
        off_t'(OFF_PREAMBLE):  b = PREAMBLE_SIZE;
        off_t'(OFF_ROOT_FL):   b = ROOT_FH;
        off_t'(OFF_ROOT_FL+1): b = ROOT_FLO;
        off_t'(OFF_ROOT_VEC):  b = ROOT_VECTOR;
        off_t'(OFF_FRAME_FL):  b = FRM_FH;
        off_t'(OFF_FRAME_FL+1): b = FRM_FLO;
        off_t'(OFF_FRAME_VEC): b = FRAME_VECTOR;
        off_t'(OFF_PRIORITY):  b = prio;
        off_t'(OFF_SEQUENCE):  b = seq;
        off_t'(OFF_UNIV_HI):   b = univ[15:8];
        off_t'(OFF_UNIV_LO):   b = univ[7:0];
        off_t'(OFF_DMP_FL):    b = DMP_FH;
        off_t'(OFF_DMP_FL+1):  b = DMP_FLO;
        off_t'(OFF_DMP_VEC):   b = DMP_VECTOR;
        off_t'(OFF_ADDR_TYPE): b = ADDR_TYPE;
        off_t'(OFF_ADDR_INC):  b = ADDR_INC;
        off_t'(OFF_COUNT_HI):  b = SLOTS_HI;
        off_t'(OFF_COUNT_LO):  b = SLOTS_LO;
        default:               b = 8'h00;
      endcase
    end
    return b;
  endfunction

  // Configuration registers.
  logic [15:0] universe_q;
  byte_t       priority_q;
  logic [15:0] expire_q;

  // Control state.
  logic [MsW-1:0]  ms_q, ms_d;
  byte_t           seq_q, seq_d;
  logic [ROWS-1:0] row_v_q, row_v_d;
  logic            s1_v_q;
  logic            out_v_q;

  // Payload registers.
  s1_t   s1_q, s1_d;
  byte_t out_data_q, out_data_d;
  logic  out_last_q;

  mode_e mode;
  logic  accept, s1_adv, has_result;
  logic  is_wr, is_merge, is_clear, is_tick, is_read, is_pkt;
  logic  wr_en, wr_lane, wr_row_v;
  logic  [RW-1:0] wr_row, rd_row;
  byte_t wr_val;
  chan_t rd_ch;
  logic  rd_in_range, expired, is_last, pkt_data;
  logic  [1:0] lane_we;
  logic  [ByteW:0] lane_wdata [2];
  logic  [ByteW:0] lane_rdata [2];
  logic  [ByteW:0] sel_rdata;

  assign mode = mode_e'(in_i.mode);

  always_comb begin
    is_wr    = 1'b0;
    is_merge = 1'b0;
    is_clear = 1'b0;
    is_tick  = 1'b0;
    is_read  = 1'b0;
    is_pkt   = 1'b0;
    unique case (mode)
      MODE_WRITE:  is_wr    = 1'b1;
      MODE_MERGE:  is_merge = 1'b1;
      MODE_CLEAR:  is_clear = 1'b1;
      MODE_TICK:   is_tick  = 1'b1;
      MODE_READ:   is_read  = 1'b1;
      MODE_PACKET: is_pkt   = 1'b1;
      default:     ;
    endcase
  end

  // Handshake: the result stage moves on whenever the output register is free or being taken.
  assign s1_adv     = !out_v_q || out_o.ready;
  assign in_i.ready = !s1_v_q || s1_adv;
  assign accept     = in_i.valid && in_i.ready;
  assign has_result = is_read || is_pkt;

  // Write and merge path, committed at the accepting edge.
  assign wr_en   = accept && (is_wr || is_merge) && (in_i.channel < chan_t'(CHANNEL_COUNT));
  assign wr_val  = (is_wr || in_i.value > in_i.other_value) ? in_i.value : in_i.other_value;
  assign wr_lane = in_i.channel[0];
  assign wr_row  = in_i.channel[RW:1];
  assign wr_row_v = wr_en && row_v_q[wr_row];

  // A write into a row that was cleared also marks the sibling channel of that row invalid.
  for (genvar l = 0; l < 2; l++) begin : g_lane
    assign lane_we[l]    = wr_en && (wr_lane == 1'(l) || !wr_row_v);
    assign lane_wdata[l] = (wr_lane == 1'(l)) ? {1'b1, wr_val} : '0;

    dmxsf_ram #(
      .WIDTH (ByteW + 1),
      .DEPTH (ROWS)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (lane_we[l]),
      .waddr_i (wr_row),
      .wdata_i (lane_wdata[l]),
      .re_i    (accept),
      .raddr_i (rd_row),
      .rdata_o (lane_rdata[l])
    );
  end

  // Read path: the channel is either the read index or the data slot of the packet offset.
  assign pkt_data    = in_i.packet_offset >= off_t'(HDR_LEN) &&
                       in_i.packet_offset < off_t'(PKT_LEN);
  assign rd_ch       = is_read ? in_i.channel : chan_t'(in_i.packet_offset - off_t'(HDR_LEN));
  assign rd_in_range = rd_ch < chan_t'(CHANNEL_COUNT);
  assign rd_row      = rd_ch[RW:1];
  assign expired     = ms_q > {1'b0, expire_q};
  assign is_last     = is_pkt && (in_i.packet_offset == off_t'(PKT_LEN - 1));

  always_comb begin
    s1_d.last     = is_last;
    s1_d.use_chan = is_read || pkt_data;
    s1_d.chan_ok  = rd_in_range && !expired && row_v_q[rd_row];
    s1_d.lane     = rd_ch[0];
    s1_d.hdr      = 8'h00;
    if (is_pkt && in_i.packet_offset < off_t'(HDR_LEN)) begin
      s1_d.hdr = hdr_byte(in_i.packet_offset, priority_q, seq_q, universe_q);
    end
  end

  assign sel_rdata  = lane_rdata[s1_q.lane];
  assign out_data_d = !s1_q.use_chan ? s1_q.hdr :
                      (s1_q.chan_ok && sel_rdata[ByteW]) ? sel_rdata[ByteW-1:0] : 8'h00;

  // Timer, sequence and row valid next state.
  always_comb begin
    ms_d    = ms_q;
    seq_d   = seq_q;
    row_v_d = row_v_q;
    if (wr_en) begin
      ms_d            = '0;
      row_v_d[wr_row] = 1'b1;
    end
    if (accept && is_tick && ms_q != '1) begin
      ms_d = ms_q + 1'b1;
    end
    if (accept && is_clear) begin
      row_v_d = '0;
    end
    if (accept && is_last) begin
      seq_d = seq_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      universe_q <= UNIVERSE_RST;
      priority_q <= PRIORITY_RST;
      expire_q   <= EXPIRE_RST;
      ms_q       <= '0;
      seq_q      <= '0;
      row_v_q    <= '0;
      s1_v_q     <= 1'b0;
      out_v_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_UNIVERSE: universe_q <= cfg_data_i;
          CFG_PRIORITY: priority_q <= cfg_data_i[ByteW-1:0];
          CFG_EXPIRE:   expire_q   <= cfg_data_i;
          default:      ;
        endcase
      end
      ms_q    <= ms_d;
      seq_q   <= seq_d;
      row_v_q <= row_v_d;
      if (in_i.ready) begin
        s1_v_q <= accept && has_result;
      end
      if (s1_adv) begin
        out_v_q <= s1_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= s1_d;
    end
    if (s1_adv && s1_v_q) begin
      out_data_q <= out_data_d;
      out_last_q <= s1_q.last;
    end
  end

  assign out_o.valid     = out_v_q;
  assign out_o.data_byte = out_data_q;
  assign out_o.last_byte = out_last_q;

  // The final packet byte advances the sequence by one.
  a_seq_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && is_last |=> seq_q == byte_t'($past(seq_q) + 8'd1))
    else $error("sequence did not advance after the final packet byte");

  // An in-range write or merge restarts the millisecond timer.
  a_timer_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> ms_q == '0)
    else $error("timer not restarted by a channel write");

  // A clear-all leaves no row valid.
  a_clear_all: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && is_clear |=> row_v_q == '0)
    else $error("rows still valid after a clear");

  // The input stalls only while both stages hold a result.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> s1_v_q && out_v_q)
    else $error("input stalled with a free stage");

endmodule

`default_nettype wire

>>> rtl/dmxsf_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
`default_nettype none

module dmxsf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire
